FILE: sv/bbc_pkg.sv
// Shared types and constants for the bracket balance checker.
// No dependencies; every other file except bbc_ram imports this package.
package bbc_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int FIFO_DEPTH      = 4;
	localparam int DEPTH_OUT_W     = 5;

	localparam logic [7:0] CH_LROUND  = 8'h28;	// (
	localparam logic [7:0] CH_RROUND  = 8'h29;	// )
	localparam logic [7:0] CH_LSQUARE = 8'h5B;	// [
	localparam logic [7:0] CH_RSQUARE = 8'h5D;	// ]
	localparam logic [7:0] CH_LCURLY  = 8'h7B;	// {
	localparam logic [7:0] CH_RCURLY  = 8'h7D;	// }

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP
	} op_t;

	typedef enum logic [1:0] {
		KIND_ROUND,
		KIND_SQUARE,
		KIND_CURLY
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_UNMATCHED,
		ERR_MISMATCH,
		ERR_UNCLOSED,
		ERR_OVERFLOW
	} err_t;

	// one classified character as it travels from front to back
	typedef struct packed {
		op_t   op;
		kind_t kind;
		logic  last;
	} bbc_op_t;

endpackage

FILE: sv/bbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/bbc_front.sv
// Front end: accepts input beats and classifies each character into an op.
// Depends on bbc_pkg.
module bbc_front
	import bbc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [7:0] char_code,
	input  logic       end_of_expr,
	output logic       op_valid,
	input  logic       op_ready,
	output bbc_op_t    op
);

	logic    valid_s1;
	bbc_op_t op_s1;
	bbc_op_t dec;

	always_comb begin
		dec.op   = OP_NONE;
		dec.kind = KIND_ROUND;
		dec.last = end_of_expr;
		case (char_code)
			CH_LROUND: begin
				dec.op = OP_PUSH;
			end
			CH_LSQUARE: begin
				dec.op   = OP_PUSH;
				dec.kind = KIND_SQUARE;
			end
			CH_LCURLY: begin
				dec.op   = OP_PUSH;
				dec.kind = KIND_CURLY;
			end
			CH_RROUND: begin
				dec.op = OP_POP;
			end
			CH_RSQUARE: begin
				dec.op   = OP_POP;
				dec.kind = KIND_SQUARE;
			end
			CH_RCURLY: begin
				dec.op   = OP_POP;
				dec.kind = KIND_CURLY;
			end
			default: begin
				dec.op = OP_NONE;
			end
		endcase
	end

	assign item_ready = !valid_s1 || op_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			op_s1 <= dec;
		end
	end

	assign op_valid = valid_s1;
	assign op       = op_s1;

endmodule

FILE: sv/bbc_fifo.sv
// Short queue of classified ops between front and back.
// Depends on bbc_pkg.
module bbc_fifo
	import bbc_pkg::*;
#(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  bbc_op_t push_data,
	output logic    pop_valid,
	input  logic    pop_ready,
	output bbc_op_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bbc_op_t       mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fifo count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("fifo count did not grow on push");

endmodule

FILE: sv/bbc_back.sv
// Back end: runs the bracket stack, keeps the sticky error and emits results.
// Depends on bbc_pkg and bbc_ram.
module bbc_back
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       op_valid,
	output logic       op_ready,
	input  bbc_op_t    op,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       is_valid,
	output logic [2:0] error_cause,
	output logic [DEPTH_OUT_W-1:0] final_depth
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	logic [DW-1:0] depth_q;
	err_t          err_q;
	kind_t         top_q;		// entry at depth-1
	logic [1:0]    below;		// entry at depth-2, from the RAM

	logic          exec;
	logic [DW-1:0] depth_op;
	err_t          err_op;
	kind_t         top_nxt;
	logic [DW-1:0] depth_nxt;
	err_t          err_nxt;
	err_t          cause;
	logic          we;
	logic [DW:0]   raddr_w;
	logic [DW+DEPTH_OUT_W-1:0] depth_ext;

	logic                   out_valid_q;
	logic                   is_valid_q;
	err_t                   cause_q;
	logic [DEPTH_OUT_W-1:0] depth_out_q;

	// a last beat needs the result slot; others never stall
	assign exec     = op_valid && (!op.last || !out_valid_q || result_ready);
	assign op_ready = exec;

	always_comb begin
		depth_op = depth_q;
		err_op   = err_q;
		top_nxt  = top_q;
		we       = 1'b0;
		if (exec && err_q == ERR_NONE) begin
			case (op.op)
				OP_PUSH: begin
					if (depth_q == DW'(STACK_DEPTH)) begin
						err_op = ERR_OVERFLOW;
					end else begin
						we       = 1'b1;
						depth_op = depth_q + 1'b1;
						top_nxt  = op.kind;
					end
				end
				OP_POP: begin
					if (depth_q == '0) begin
						err_op = ERR_UNMATCHED;
					end else begin
						depth_op = depth_q - 1'b1;
						top_nxt  = kind_t'(below);
						if (top_q != op.kind) begin
							err_op = ERR_MISMATCH;
						end
					end
				end
				default: begin
					depth_op = depth_q;
				end
			endcase
		end
	end

	always_comb begin
		cause = err_op;
		if (err_op == ERR_NONE && depth_op != '0) begin
			cause = ERR_UNCLOSED;
		end
		depth_nxt = depth_op;
		err_nxt   = err_op;
		if (exec && op.last) begin
			depth_nxt = '0;
			err_nxt   = ERR_NONE;
		end
	end

	assign depth_ext = {{DEPTH_OUT_W{1'b0}}, depth_op};
	// prefetch the entry under the new top for the next pop
	assign raddr_w   = {1'b0, depth_nxt} - (DW + 1)'(2);

	bbc_ram #(
		.WIDTH (2),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (depth_q[AW-1:0]),
		.wdata (op.kind),
		.raddr (raddr_w[AW-1:0]),
		.rdata (below)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			depth_q <= depth_nxt;
			err_q   <= err_nxt;
			if (exec && op.last) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_nxt;
		if (exec && op.last) begin
			is_valid_q  <= (cause == ERR_NONE);
			cause_q     <= cause;
			depth_out_q <= depth_ext[DEPTH_OUT_W-1:0];
		end
	end

	assign result_valid = out_valid_q;
	assign is_valid     = is_valid_q;
	assign error_cause  = cause_q;
	assign final_depth  = depth_out_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && op.last) |=> (depth_q == '0 && err_q == ERR_NONE))
		else $error("state not cleared after last beat");

	a_valid_vs_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (is_valid_q == (cause_q == ERR_NONE)))
		else $error("is_valid disagrees with error cause");

	a_sticky_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ERR_NONE && !(exec && op.last)) |=> err_q == $past(err_q))
		else $error("sticky error changed inside an expression");

endmodule

FILE: sv/bracket_balance_checker.sv
// A result is registered once the beat carrying end_of_expr has passed the front register, the op queue and the stack.
// Throughput: one character per cycle while results are taken; the stack does one push
// or pop per cycle, using a registered top entry and a prefetched RAM read of the entry below it.
// A 4-entry op queue decouples the classifier from the stack engine.
// Reset (arst_n low, async): empties queue and stack, clears the error and result_valid.
module bracket_balance_checker
	import bbc_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [7:0] char_code,
	input  logic       end_of_expr,
	output logic       result_valid,
	input  logic       result_ready,
	output logic       is_valid,
	output logic [2:0] error_cause,
	output logic [DEPTH_OUT_W-1:0] final_depth
);

	logic    f_valid;
	logic    f_ready;
	bbc_op_t f_op;
	logic    b_valid;
	logic    b_ready;
	bbc_op_t b_op;

	bbc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.char_code   (char_code),
		.end_of_expr (end_of_expr),
		.op_valid    (f_valid),
		.op_ready    (f_ready),
		.op          (f_op)
	);

	bbc_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_op),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_op)
	);

	bbc_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (b_valid),
		.op_ready     (b_ready),
		.op           (b_op),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.is_valid     (is_valid),
		.error_cause  (error_cause),
		.final_depth  (final_depth)
	);

endmodule
